FILE: sv/rlcm_pkg.sv
// types, codes and reset values shared by the radio link coordinator mac core
// and its step logic; no dependencies
`default_nettype none

package rlcm_pkg;

  localparam int unsigned CFG_DW   = 26;
  localparam int unsigned CFG_IDXW = 3;

  localparam logic [19:0] POLL_CAP_US = 20'd1000000;
  localparam logic [7:0]  STREAK_MAX  = 8'hFF;

  localparam logic [7:0]  FAIR_BURST_RST   = 8'd4;
  localparam logic [7:0]  GRANT_BURST_RST  = 8'd8;
  localparam logic [7:0]  DISC_THR_RST     = 8'd5;
  localparam logic [23:0] INIT_BACKOFF_RST = 24'd100000;
  localparam logic [25:0] MAX_BACKOFF_RST  = 26'd5000000;
  localparam logic [19:0] IDLE_POLL_RST    = 20'd10000;
  localparam logic [19:0] ACTIVE_POLL_RST  = 20'd1000;

  typedef enum logic [1:0] {
    MODE_RESET_SYNC  = 2'd0,
    MODE_IDLE        = 2'd1,
    MODE_ISSUE_GRANT = 2'd2,
    MODE_ACTIVE_RX   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    FR_RESET   = 3'd0,
    FR_GRANT   = 3'd1,
    FR_DATA    = 3'd2,
    FR_PENDING = 3'd3,
    FR_ACK     = 3'd4
  } frame_e;

  typedef enum logic [2:0] {
    OP_CHOOSE    = 3'd0,
    OP_PEER_RESP = 3'd1,
    OP_SEND_FAIL = 3'd2,
    OP_TIMEOUT   = 3'd3,
    OP_DECODE    = 3'd4,
    OP_RESET_RES = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CFG_FAIR_BURST   = 3'd0,
    CFG_GRANT_BURST  = 3'd1,
    CFG_DISC_THR     = 3'd2,
    CFG_INIT_BACKOFF = 3'd3,
    CFG_MAX_BACKOFF  = 3'd4,
    CFG_IDLE_POLL    = 3'd5,
    CFG_ACTIVE_POLL  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FAIL_SEND     = 2'd0,
    FAIL_TIMEOUT  = 2'd1,
    FAIL_PROTOCOL = 2'd2
  } fail_e;

  typedef struct packed {
    logic [7:0]  fair_burst;
    logic [7:0]  grant_burst;
    logic [7:0]  disc_thr;
    logic [23:0] init_backoff;
    logic [25:0] max_backoff;
    logic [19:0] idle_poll;
    logic [19:0] active_poll;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic        peer_pending;
    frame_e      last_sent;
    logic [7:0]  data_run;
    logic [7:0]  snd_fail_run;
    logic [7:0]  tmo_streak;
    logic        disconnected;
    logic        reset_pending;
    logic [25:0] backoff;
  } state_t;

  typedef struct packed {
    logic [2:0]  tx_type;
    logic        tx_pending;
    logic [7:0]  tx_arg;
    logic        status;
    logic        link_down;
    logic        reset_needed;
    logic [25:0] retry_backoff;
    logic [19:0] poll_interval;
    logic [8:0]  fail_total;
    logic [1:0]  coord_state;
  } rslt_t;

  typedef struct packed {
    logic [7:0] snd_fail_run;
    logic [7:0] tmo_streak;
    logic       disc;
  } fail_t;

endpackage

`default_nettype wire

FILE: sv/rlcm_step.sv
// one event of the coordinator: next link state and the result fields
// depends on rlcm_pkg
`default_nettype none

module rlcm_step import rlcm_pkg::*; (
  input  cfg_t       cfg_i,
  input  state_t     st_i,
  input  logic [2:0] opcode_i,
  input  logic       local_has_data_i,
  input  logic [2:0] rx_type_i,
  input  logic       rx_pending_i,
  input  logic       reset_ok_i,
  output state_t     st_o,
  output rslt_t      res_o
);

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == STREAK_MAX) ? v : v + 8'd1;
  endfunction

  function automatic fail_t count_fail(input fail_e kind, input logic [7:0] s,
                                       input logic [7:0] t, input logic [7:0] thr);
    fail_t r;
    case (kind)
      FAIL_SEND: begin
        r.snd_fail_run = sat_inc(s);
        r.tmo_streak   = 8'd0;
      end
      FAIL_TIMEOUT: begin
        r.snd_fail_run = 8'd0;
        r.tmo_streak   = sat_inc(t);
      end
      default: begin
        r.snd_fail_run = sat_inc(s);
        r.tmo_streak   = sat_inc(t);
      end
    endcase
    r.disc = (r.snd_fail_run >= thr) ||
             ({1'b0, r.tmo_streak} >= ({1'b0, thr} + 9'd2)) ||
             (({1'b0, r.snd_fail_run} + {1'b0, r.tmo_streak}) >= ({1'b0, thr} + 9'd3));
    return r;
  endfunction

  fail_t       fl_send;
  fail_t       fl_tmo;
  fail_t       fl_proto;
  logic        rx_good;
  logic [26:0] backoff_dbl;
  logic [25:0] backoff_grown;
  logic [19:0] poll_sel;
  frame_e      tx_type;
  logic        tx_pending;
  logic [7:0]  tx_arg;
  logic        status;

  assign fl_send  = count_fail(FAIL_SEND, st_i.snd_fail_run, st_i.tmo_streak, cfg_i.disc_thr);
  assign fl_tmo   = count_fail(FAIL_TIMEOUT, st_i.snd_fail_run, st_i.tmo_streak,
                               cfg_i.disc_thr);
  assign fl_proto = count_fail(FAIL_PROTOCOL, st_i.snd_fail_run, st_i.tmo_streak,
                               cfg_i.disc_thr);

  assign rx_good = (rx_type_i == FR_ACK) || (rx_type_i == FR_PENDING) ||
                   (rx_type_i == FR_DATA);

  assign backoff_dbl   = {st_i.backoff, 1'b0};
  assign backoff_grown = (backoff_dbl > {1'b0, cfg_i.max_backoff}) ? cfg_i.max_backoff
                                                                    : backoff_dbl[25:0];

  // frame choice and status
  always_comb begin
    tx_type    = FR_RESET;
    tx_pending = 1'b0;
    tx_arg     = 8'd0;
    status     = 1'b0;
    case (opcode_i)
      OP_CHOOSE: begin
        if (st_i.mode == MODE_RESET_SYNC) begin
          tx_type = FR_RESET;
        end else if (st_i.mode != MODE_IDLE) begin
          tx_type    = FR_GRANT;
          tx_pending = local_has_data_i;
          tx_arg     = cfg_i.grant_burst;
        end else if (local_has_data_i) begin
          // grant the peer a turn once our own burst has run long enough
          if (st_i.peer_pending && (st_i.data_run >= cfg_i.fair_burst)) begin
            tx_type = FR_GRANT;
            tx_arg  = cfg_i.grant_burst;
          end else begin
            tx_type = FR_DATA;
          end
          tx_pending = 1'b1;
        end else begin
          tx_type = FR_PENDING;
        end
      end
      OP_PEER_RESP: status = !rx_good;
      OP_DECODE:    status = 1'b1;
      OP_RESET_RES: status = !reset_ok_i;
      default:      status = 1'b0;
    endcase
  end

  // next link state
  always_comb begin
    st_o = st_i;
    case (opcode_i)
      OP_CHOOSE: st_o.last_sent = tx_type;
      OP_PEER_RESP: begin
        st_o.peer_pending = rx_pending_i;
        if (rx_good) begin
          if (rx_type_i == FR_PENDING) begin
            st_o.mode = MODE_ISSUE_GRANT;
          end else if (rx_type_i == FR_ACK) begin
            st_o.mode = rx_pending_i ? MODE_ISSUE_GRANT : MODE_IDLE;
          end else begin
            st_o.mode = rx_pending_i ? MODE_ACTIVE_RX : MODE_IDLE;
          end
          if ((st_i.last_sent == FR_DATA) && (rx_type_i != FR_DATA)) begin
            st_o.data_run = sat_inc(st_i.data_run);
          end else begin
            st_o.data_run = 8'd0;
          end
          st_o.snd_fail_run = 8'd0;
          st_o.tmo_streak   = 8'd0;
          st_o.disconnected = 1'b0;
          st_o.backoff      = {2'b00, cfg_i.init_backoff};
        end else begin
          st_o.data_run     = 8'd0;
          st_o.snd_fail_run = fl_proto.snd_fail_run;
          st_o.tmo_streak   = fl_proto.tmo_streak;
          if (fl_proto.disc) begin
            st_o.disconnected  = 1'b1;
            st_o.reset_pending = 1'b1;
            st_o.mode          = MODE_RESET_SYNC;
          end
        end
      end
      OP_SEND_FAIL: begin
        st_o.snd_fail_run = fl_send.snd_fail_run;
        st_o.tmo_streak   = fl_send.tmo_streak;
        if (fl_send.disc) begin
          st_o.disconnected  = 1'b1;
          st_o.reset_pending = 1'b1;
          st_o.mode          = MODE_RESET_SYNC;
        end
      end
      OP_TIMEOUT: begin
        st_o.snd_fail_run = fl_tmo.snd_fail_run;
        st_o.tmo_streak   = fl_tmo.tmo_streak;
        if (fl_tmo.disc) begin
          st_o.disconnected  = 1'b1;
          st_o.reset_pending = 1'b1;
          st_o.mode          = MODE_RESET_SYNC;
        end
      end
      OP_DECODE: begin
        st_o.snd_fail_run = fl_proto.snd_fail_run;
        st_o.tmo_streak   = fl_proto.tmo_streak;
        if (fl_proto.disc) begin
          st_o.disconnected  = 1'b1;
          st_o.reset_pending = 1'b1;
          st_o.mode          = MODE_RESET_SYNC;
        end
      end
      OP_RESET_RES: begin
        st_o.peer_pending = 1'b0;
        st_o.data_run     = 8'd0;
        st_o.last_sent    = FR_RESET;
        if (reset_ok_i) begin
          st_o.snd_fail_run  = 8'd0;
          st_o.tmo_streak    = 8'd0;
          st_o.disconnected  = 1'b0;
          st_o.backoff       = {2'b00, cfg_i.init_backoff};
          st_o.reset_pending = 1'b0;
          st_o.mode          = MODE_IDLE;
        end else if (st_i.disconnected) begin
          st_o.backoff = backoff_grown;
        end else begin
          st_o.snd_fail_run = fl_proto.snd_fail_run;
          st_o.tmo_streak   = fl_proto.tmo_streak;
          if (fl_proto.disc) begin
            st_o.disconnected  = 1'b1;
            st_o.reset_pending = 1'b1;
            st_o.mode          = MODE_RESET_SYNC;
          end
        end
      end
      default: st_o = st_i;
    endcase
  end

  assign poll_sel = ((st_o.mode == MODE_IDLE) && !st_o.peer_pending) ? cfg_i.idle_poll
                                                                      : cfg_i.active_poll;

  always_comb begin
    res_o.tx_type       = tx_type;
    res_o.tx_pending    = tx_pending;
    res_o.tx_arg        = tx_arg;
    res_o.status        = status;
    res_o.link_down     = st_o.disconnected;
    res_o.reset_needed  = st_o.reset_pending;
    res_o.retry_backoff = st_o.backoff;
    res_o.poll_interval = (poll_sel > POLL_CAP_US) ? POLL_CAP_US : poll_sel;
    res_o.fail_total    = {1'b0, st_o.snd_fail_run} + {1'b0, st_o.tmo_streak};
    res_o.coord_state   = st_o.mode;
  end

endmodule

`default_nettype wire

FILE: sv/radio_link_coordinator_mac_core.sv
// radio link coordinator mac: top level with config registers, input and result stages
// depends on rlcm_pkg and rlcm_step
//
// Usage: every event (choose frame, peer response, send fail, timeout, decode
// fail, reset result) enters on the input channel (in_valid_i / in_ready_o) and
// produces exactly one result transaction on the output channel
// (out_valid_o / out_ready_i) carrying the frame to send, status, link flags,
// backoff, poll interval, failure streak and coordinator state.
// Path: an event that is taken sits in the input register and is then
// processed into the result register, from which its result is offered.
// Throughput: one event per cycle while out_ready_i is high; the link state
// update is a single pass of combinational logic between the input register
// and the result register.
// Stall: while out_ready_i is low the result register holds, the input register
// can still fill, and in_ready_o drops only when both stages are occupied.
// Reset: rst_ni clears both stages, loads the register defaults and puts the
// coordinator in reset-sync with a reset handshake pending.
// Configuration: cfg_we_i writes register cfg_idx_i at the clock edge; write only
// while no event is in flight.
`default_nettype none

module radio_link_coordinator_mac_core import rlcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          opcode_i,
  input  logic                local_has_data_i,
  input  logic [2:0]          rx_type_i,
  input  logic                rx_pending_i,
  input  logic                reset_ok_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          tx_type_o,
  output logic                tx_pending_o,
  output logic [7:0]          tx_arg_o,
  output logic                status_o,
  output logic                link_down_o,
  output logic                reset_needed_o,
  output logic [25:0]         retry_backoff_us_o,
  output logic [19:0]         poll_gap_us_o,
  output logic [8:0]          fail_total_o,
  output logic [1:0]          coord_state_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  state_t     st_q;
  state_t     st_d;
  rslt_t      res_q;
  rslt_t      res_d;
  logic       in_vld_q;
  logic       in_vld_d;
  logic       out_vld_q;
  logic       out_vld_d;
  logic [2:0] op_q;
  logic       has_data_q;
  logic [2:0] rx_type_q;
  logic       rx_pend_q;
  logic       rst_ok_q;
  logic       in_take;
  logic       advance;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FAIR_BURST:   cfg_d.fair_burst   = cfg_wdata_i[7:0];
        CFG_GRANT_BURST:  cfg_d.grant_burst  = cfg_wdata_i[7:0];
        CFG_DISC_THR:     cfg_d.disc_thr     = cfg_wdata_i[7:0];
        CFG_INIT_BACKOFF: cfg_d.init_backoff = cfg_wdata_i[23:0];
        CFG_MAX_BACKOFF:  cfg_d.max_backoff  = cfg_wdata_i[25:0];
        CFG_IDLE_POLL:    cfg_d.idle_poll    = cfg_wdata_i[19:0];
        CFG_ACTIVE_POLL:  cfg_d.active_poll  = cfg_wdata_i[19:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fair_burst   <= FAIR_BURST_RST;
      cfg_q.grant_burst  <= GRANT_BURST_RST;
      cfg_q.disc_thr     <= DISC_THR_RST;
      cfg_q.init_backoff <= INIT_BACKOFF_RST;
      cfg_q.max_backoff  <= MAX_BACKOFF_RST;
      cfg_q.idle_poll    <= IDLE_POLL_RST;
      cfg_q.active_poll  <= ACTIVE_POLL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // handshake: the input stage moves on whenever the result register is free
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || !out_vld_q || out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q       <= opcode_i;
      has_data_q <= local_has_data_i;
      rx_type_q  <= rx_type_i;
      rx_pend_q  <= rx_pending_i;
      rst_ok_q   <= reset_ok_i;
    end
  end

  rlcm_step u_step (
    .cfg_i            (cfg_q),
    .st_i             (st_q),
    .opcode_i         (op_q),
    .local_has_data_i (has_data_q),
    .rx_type_i        (rx_type_q),
    .rx_pending_i     (rx_pend_q),
    .reset_ok_i       (rst_ok_q),
    .st_o             (st_d),
    .res_o            (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode          <= MODE_RESET_SYNC;
      st_q.peer_pending  <= 1'b0;
      st_q.last_sent     <= FR_RESET;
      st_q.data_run      <= 8'd0;
      st_q.snd_fail_run  <= 8'd0;
      st_q.tmo_streak    <= 8'd0;
      st_q.disconnected  <= 1'b0;
      st_q.reset_pending <= 1'b1;
      st_q.backoff       <= {2'b00, INIT_BACKOFF_RST};
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign tx_type_o          = res_q.tx_type;
  assign tx_pending_o       = res_q.tx_pending;
  assign tx_arg_o           = res_q.tx_arg;
  assign status_o           = res_q.status;
  assign link_down_o        = res_q.link_down;
  assign reset_needed_o     = res_q.reset_needed;
  assign retry_backoff_us_o = res_q.retry_backoff;
  assign poll_gap_us_o      = res_q.poll_interval;
  assign fail_total_o       = res_q.fail_total;
  assign coord_state_o      = res_q.coord_state;

  // a dropped link always waits for a reset handshake
  a_disc_needs_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.disconnected |-> st_q.reset_pending)
    else $error("link down without a pending reset");

  // an empty result register never blocks the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // only grant frames carry a burst argument
  a_arg_only_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.tx_arg != 8'd0)) |-> (res_q.tx_type == FR_GRANT))
    else $error("burst argument on a non-grant frame");

endmodule

`default_nettype wire
